[design/etf_pkg.sv]
`default_nettype none

package etf_pkg;

  // Default datapath geometry
  localparam int WORD_BITS_DEF     = 32;
  localparam int FRACTION_BITS_DEF = 24;
  localparam int LIMIT_BITS_DEF    = 16;

  // Configuration register map
  localparam int CFG_INDEX_BITS = 3;
  localparam logic [CFG_INDEX_BITS-1:0] REG_JULIA_MODE = 3'd0;
  localparam logic [CFG_INDEX_BITS-1:0] REG_CONST_RE   = 3'd1;
  localparam logic [CFG_INDEX_BITS-1:0] REG_CONST_IM   = 3'd2;
  localparam logic [CFG_INDEX_BITS-1:0] REG_ITER_LIMIT = 3'd3;
  localparam logic [CFG_INDEX_BITS-1:0] REG_BAILOUT_SQ = 3'd4;

  // Reset values of the limit and of the bailout in whole units
  localparam logic [63:0] ITER_LIMIT_RESET  = 64'd512;
  localparam logic [63:0] BAILOUT_UNITS_RESET = 64'd100;

endpackage

`default_nettype wire

[design/etf_mul.sv]
`default_nettype none

module etf_mul #(
  parameter int WORD_BITS = etf_pkg::WORD_BITS_DEF
) (
  input  wire logic                          clk,
  input  wire logic signed [WORD_BITS-1:0]   op_a,
  input  wire logic signed [WORD_BITS-1:0]   op_b,
  output logic signed      [2*WORD_BITS-1:0] prod_r
);
  import etf_pkg::*;

  logic signed [2*WORD_BITS-1:0] prod_nxt;

  // Full-width signed product
  assign prod_nxt = op_a * op_b;

  // Register the product for the next step of the sequencer
  always_ff @(posedge clk) begin
    prod_r <= prod_nxt;
  end

endmodule

`default_nettype wire

[design/escape_time_fractal_iterator.sv]
// Escape-time iterator for Mandelbrot and Julia sets, signed fixed point.
// Input channel (in_valid/in_ready) carries one complex point per transaction.
// Output channel (out_valid/out_ready) returns the loop test count and the
// escaped flag, one transaction per point, in order.
// Configuration: cfg_write_en writes cfg_data into the register at cfg_index
// (0 julia_mode, 1 const_re, 2 const_im, 3 iter_limit, 4 bailout_sq); write
// only while the block is idle. Other indexes are ignored.
// One shared signed multiplier is reused for r*r, s*s and r*s; each iteration
// steps through square real, square imaginary, test plus cross product, update.
// The block takes one point at a time; in_ready returns with the result.
// A result waiting in the output register does not block the next point, but
// a finished point waits until the output register is free.
// Reset (rst_n low, synchronous) empties the block and loads the registers
// with Mandelbrot mode, constant 0, limit 512 and bailout 100.0.
`default_nettype none

module escape_time_fractal_iterator #(
  parameter int WORD_BITS     = etf_pkg::WORD_BITS_DEF,
  parameter int FRACTION_BITS = etf_pkg::FRACTION_BITS_DEF,
  parameter int LIMIT_BITS    = etf_pkg::LIMIT_BITS_DEF
) (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  input  wire logic                                in_valid,
  output logic                                     in_ready,
  input  wire logic [WORD_BITS-1:0]                in_point_re,
  input  wire logic [WORD_BITS-1:0]                in_point_im,
  output logic                                     out_valid,
  input  wire logic                                out_ready,
  output logic [LIMIT_BITS:0]                      out_test_count,
  output logic                                     out_escaped,
  input  wire logic                                cfg_write_en,
  input  wire logic [etf_pkg::CFG_INDEX_BITS-1:0]  cfg_index,
  input  wire logic [WORD_BITS-1:0]                cfg_data
);
  import etf_pkg::*;

  localparam int PROD_BITS = 2 * WORD_BITS;
  localparam int WIDE_BITS = 2 * WORD_BITS + 2;
  localparam logic [LIMIT_BITS-1:0] LIMIT_RESET = ITER_LIMIT_RESET[LIMIT_BITS-1:0];
  localparam logic [63:0] BAIL_RESET_FULL = BAILOUT_UNITS_RESET << FRACTION_BITS;
  localparam logic [WORD_BITS-2:0] BAIL_RESET = BAIL_RESET_FULL[WORD_BITS-2:0];

  typedef enum logic [5:0] {
    ST_IDLE   = 6'b000001,
    ST_SQ_RE  = 6'b000010,
    ST_SQ_IM  = 6'b000100,
    ST_TEST   = 6'b001000,
    ST_UPDATE = 6'b010000,
    ST_DONE   = 6'b100000
  } state_t;

  state_t state_r, state_nxt;

  // Configuration registers
  logic                  julia_mode_r;
  logic [WORD_BITS-1:0]  const_re_r;
  logic [WORD_BITS-1:0]  const_im_r;
  logic [LIMIT_BITS-1:0] iter_limit_r;
  logic [WORD_BITS-2:0]  bailout_r;

  // Iteration state
  logic [WORD_BITS-1:0]  z_re_r, z_im_r;
  logic [WORD_BITS-1:0]  c_re_r, c_im_r;
  logic [WORD_BITS-1:0]  z_re_new_r;
  logic [PROD_BITS-1:0]  rr_r;
  logic [LIMIT_BITS:0]   count_r;

  // Output register
  logic                  out_valid_r;
  logic [LIMIT_BITS:0]   out_count_r;
  logic                  out_escaped_r;

  // Shared multiplier
  logic signed [WORD_BITS-1:0] mul_a, mul_b;
  logic signed [PROD_BITS-1:0] prod;

  logic                  in_fire;
  logic                  out_free;
  logic [PROD_BITS-1:0]  mag;
  logic [PROD_BITS-1:0]  thresh;
  logic                  test_pass;
  logic signed [PROD_BITS:0]   diff;
  logic signed [PROD_BITS:0]   diff_sh;
  logic signed [PROD_BITS-1:0] rs_sh;
  logic [WIDE_BITS-1:0]  re_wide;
  logic [WIDE_BITS-1:0]  im_wide;
  logic [WORD_BITS-1:0]  re_sat;
  logic [WORD_BITS-1:0]  im_sat;

  function automatic logic [WORD_BITS-1:0] sat_word(input logic [WIDE_BITS-1:0] v);
    logic ovf;
    ovf = (v[WIDE_BITS-1:WORD_BITS-1] != {(WORD_BITS+3){v[WIDE_BITS-1]}});
    if (!ovf) begin
      return v[WORD_BITS-1:0];
    end else if (v[WIDE_BITS-1]) begin
      return {1'b1, {(WORD_BITS-1){1'b0}}};
    end else begin
      return {1'b0, {(WORD_BITS-1){1'b1}}};
    end
  endfunction

  assign in_ready       = (state_r == ST_IDLE);
  assign in_fire        = in_valid && in_ready;
  assign out_valid      = out_valid_r;
  assign out_test_count = out_count_r;
  assign out_escaped    = out_escaped_r;
  assign out_free       = !out_valid_r || out_ready;

  // Select multiplier operands per step
  always_comb begin
    mul_a = $signed(z_re_r);
    mul_b = $signed(z_re_r);
    case (state_r)
      ST_SQ_IM: begin
        mul_a = $signed(z_im_r);
        mul_b = $signed(z_im_r);
      end
      ST_TEST: begin
        mul_a = $signed(z_re_r);
        mul_b = $signed(z_im_r);
      end
      default: begin
        mul_a = $signed(z_re_r);
        mul_b = $signed(z_re_r);
      end
    endcase
  end

  etf_mul #(
    .WORD_BITS (WORD_BITS)
  ) u_mul (
    .clk    (clk),
    .op_a   (mul_a),
    .op_b   (mul_b),
    .prod_r (prod)
  );

  // Magnitude test: prod holds s*s in the test step
  assign mag       = rr_r + prod;
  assign thresh    = {{(WORD_BITS+1-FRACTION_BITS){1'b0}}, bailout_r, {FRACTION_BITS{1'b0}}};
  assign test_pass = (count_r < {1'b0, iter_limit_r}) && (mag < thresh);

  // Real update: floor((r*r - s*s) / 2^F) + c_re
  assign diff    = $signed({1'b0, rr_r}) - $signed({1'b0, prod});
  assign diff_sh = diff >>> FRACTION_BITS;
  assign re_wide = {diff_sh[PROD_BITS], diff_sh}
                 + {{(WORD_BITS+2){c_re_r[WORD_BITS-1]}}, c_re_r};
  assign re_sat  = sat_word(re_wide);

  // Imaginary update: floor(r*s / 2^(F-1)) + c_im, prod holds r*s here
  assign rs_sh   = prod >>> (FRACTION_BITS - 1);
  assign im_wide = {{2{rs_sh[PROD_BITS-1]}}, rs_sh}
                 + {{(WORD_BITS+2){c_im_r[WORD_BITS-1]}}, c_im_r};
  assign im_sat  = sat_word(im_wide);

  // Advance the sequencer
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE:   if (in_fire) state_nxt = ST_SQ_RE;
      ST_SQ_RE:  state_nxt = ST_SQ_IM;
      ST_SQ_IM:  state_nxt = ST_TEST;
      ST_TEST:   state_nxt = test_pass ? ST_UPDATE : ST_DONE;
      ST_UPDATE: state_nxt = ST_SQ_RE;
      ST_DONE:   if (out_free) state_nxt = ST_IDLE;
      default:   state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Write configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      julia_mode_r <= 1'b0;
      const_re_r   <= '0;
      const_im_r   <= '0;
      iter_limit_r <= LIMIT_RESET;
      bailout_r    <= BAIL_RESET;
    end else if (cfg_write_en) begin
      unique case (cfg_index)
        REG_JULIA_MODE: julia_mode_r <= cfg_data[0];
        REG_CONST_RE:   const_re_r   <= cfg_data;
        REG_CONST_IM:   const_im_r   <= cfg_data;
        REG_ITER_LIMIT: iter_limit_r <= cfg_data[LIMIT_BITS-1:0];
        REG_BAILOUT_SQ: bailout_r    <= cfg_data[WORD_BITS-2:0];
        default: ;
      endcase
    end
  end

  // Load the point, iterate z and count tests
  always_ff @(posedge clk) begin
    if (in_fire) begin
      if (julia_mode_r) begin
        z_re_r <= in_point_re;
        z_im_r <= in_point_im;
        c_re_r <= const_re_r;
        c_im_r <= const_im_r;
      end else begin
        z_re_r <= '0;
        z_im_r <= '0;
        c_re_r <= in_point_re;
        c_im_r <= in_point_im;
      end
      count_r <= '0;
    end
    if (state_r == ST_SQ_IM) begin
      rr_r <= prod;
    end
    if (state_r == ST_TEST) begin
      z_re_new_r <= re_sat;
      count_r    <= count_r + 1'b1;
    end
    if (state_r == ST_UPDATE) begin
      z_re_r <= z_re_new_r;
      z_im_r <= im_sat;
    end
  end

  // Hold the result until the receiver takes it
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (state_r == ST_DONE && out_free) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == ST_DONE && out_free) begin
      out_count_r   <= count_r;
      out_escaped_r <= (count_r < {1'b0, iter_limit_r});
    end
  end

endmodule

`default_nettype wire

[dv/tb_escape_time_fractal_iterator.sv]
`timescale 1ns / 100ps

module tb_escape_time_fractal_iterator;

  localparam int WB = etf_pkg::WORD_BITS_DEF;
  localparam int FB = etf_pkg::FRACTION_BITS_DEF;
  localparam int LB = etf_pkg::LIMIT_BITS_DEF;
  localparam int IB = etf_pkg::CFG_INDEX_BITS;

  localparam int ONE = 1 << FB;
  localparam logic [WB-1:0] WORD_HI = {1'b0, {(WB-1){1'b1}}};
  localparam logic [WB-1:0] WORD_LO = {1'b1, {(WB-1){1'b0}}};
  localparam longint SAT_HI = (longint'(1) <<< (WB - 1)) - 1;
  localparam longint SAT_LO = -SAT_HI - 1;
  localparam int HOLD_OFF_CYCLES = 3000;
  localparam logic [63:0] BAIL_RESET_FULL = etf_pkg::BAILOUT_UNITS_RESET << FB;

  typedef struct packed {
    logic [WB-1:0] re;
    logic [WB-1:0] im;
  } point_t;

  typedef struct packed {
    logic [LB:0] count;
    logic        escaped;
  } escape_result_t;

  logic clk;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [WB-1:0] in_point_re = '0;
  logic [WB-1:0] in_point_im = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [LB:0] out_test_count;
  logic out_escaped;
  logic cfg_write_en = 1'b0;
  logic [IB-1:0] cfg_index = '0;
  logic [WB-1:0] cfg_data = '0;

  // Shadow copy of the configuration registers
  logic          julia_on = 1'b0;
  logic [WB-1:0] julia_re = '0;
  logic [WB-1:0] julia_im = '0;
  logic [LB-1:0] max_iters = etf_pkg::ITER_LIMIT_RESET[LB-1:0];
  logic [WB-2:0] bail_sq = BAIL_RESET_FULL[WB-2:0];

  point_t         pending_points[$];
  escape_result_t expected_escapes[$];
  point_t         next_point;
  escape_result_t oldest_escape;

  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int hold_requests = 0;
  int holds_served = 0;
  int hold_left = 0;
  int mismatch_count = 0;

  escape_time_fractal_iterator dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_point_re    (in_point_re),
    .in_point_im    (in_point_im),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_test_count (out_test_count),
    .out_escaped    (out_escaped),
    .cfg_write_en   (cfg_write_en),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic longint clamp_word(input longint v);
    if (v > SAT_HI) return SAT_HI;
    if (v < SAT_LO) return SAT_LO;
    return v;
  endfunction

  // Run the escape-time loop on one point with the shadow configuration
  function automatic escape_result_t iterate_point(input logic [WB-1:0] pre,
                                                   input logic [WB-1:0] pim);
    longint zr, zi, cr, ci, rr, ss, rs;
    longint unsigned mag, thresh;
    int unsigned tests, k;
    bit running;
    escape_result_t res;
    thresh = longint'(bail_sq) << FB;
    if (julia_on) begin
      zr = longint'($signed(pre));
      zi = longint'($signed(pim));
      cr = longint'($signed(julia_re));
      ci = longint'($signed(julia_im));
    end else begin
      zr = 0;
      zi = 0;
      cr = longint'($signed(pre));
      ci = longint'($signed(pim));
    end
    tests = 0;
    running = 1'b1;
    while (running) begin
      k = tests;
      rr = zr * zr;
      ss = zi * zi;
      rs = zr * zi;
      mag = rr + ss;
      tests = tests + 1;
      if (k < max_iters && mag < thresh) begin
        zr = clamp_word(((rr - ss) >>> FB) + cr);
        zi = clamp_word((rs >>> (FB - 1)) + ci);
      end else begin
        running = 1'b0;
      end
    end
    res.count = tests[LB:0];
    res.escaped = (tests < max_iters);
    return res;
  endfunction

  task automatic report_mismatch(input string msg);
    $display("ERROR at %0t: %s", $time, msg);
    mismatch_count++;
  endtask

  // Write one register and track it in the shadow copy
  task automatic write_register(input logic [IB-1:0] idx, input logic [WB-1:0] data);
    @(posedge clk);
    cfg_write_en <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    case (idx)
      etf_pkg::REG_JULIA_MODE: julia_on = data[0];
      etf_pkg::REG_CONST_RE:   julia_re = data;
      etf_pkg::REG_CONST_IM:   julia_im = data;
      etf_pkg::REG_ITER_LIMIT: max_iters = data[LB-1:0];
      etf_pkg::REG_BAILOUT_SQ: bail_sq = data[WB-2:0];
      default: ;
    endcase
    @(posedge clk);
    cfg_write_en <= 1'b0;
  endtask

  task automatic configure(input logic julia, input logic [WB-1:0] cre,
                           input logic [WB-1:0] cim, input logic [WB-1:0] limit,
                           input logic [WB-1:0] bail);
    write_register(etf_pkg::REG_JULIA_MODE, {{(WB-1){1'b0}}, julia});
    write_register(etf_pkg::REG_CONST_RE, cre);
    write_register(etf_pkg::REG_CONST_IM, cim);
    write_register(etf_pkg::REG_ITER_LIMIT, limit);
    write_register(etf_pkg::REG_BAILOUT_SQ, bail);
  endtask

  task automatic queue_point(input logic [WB-1:0] re, input logic [WB-1:0] im);
    @(negedge clk);
    pending_points.push_back('{re, im});
  endtask

  // Mostly points around the set, some near the origin, some anywhere; far_only gives far points
  task automatic queue_points(input int count, input bit far_only);
    logic [WB-1:0] re, im;
    int pick;
    @(negedge clk);
    for (int n = 0; n < count; n++) begin
      pick = $urandom_range(0, 99);
      if (far_only) begin
        re = $urandom_range(32'h0800_0000, 32'h7FFF_FFFF);
        if ($urandom_range(0, 1)) re = ~re;
        im = $urandom;
      end else if (pick < 65) begin
        re = $urandom_range(0, 32'h0380_0000) - 32'h0280_0000;
        im = $urandom_range(0, 32'h0300_0000) - 32'h0180_0000;
      end else if (pick < 80) begin
        re = $urandom_range(0, 32'h0040_0000) - 32'h0020_0000;
        im = $urandom_range(0, 32'h0040_0000) - 32'h0020_0000;
      end else begin
        re = $urandom;
        im = $urandom;
      end
      pending_points.push_back('{re, im});
    end
  endtask

  // Hold until every queued point is sent and every result is back
  task automatic drain();
    @(negedge clk);
    while (pending_points.size() != 0 || in_valid || expected_escapes.size() != 0)
      @(negedge clk);
  endtask

  task automatic set_idling(input int send_pct, input int recv_pct);
    send_idle_pct = send_pct;
    recv_idle_pct = recv_pct;
  endtask

  // Driver: predict at acceptance, then offer the next point or idle
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && in_ready)
        expected_escapes.push_back(iterate_point(in_point_re, in_point_im));
      if (!in_valid || in_ready) begin
        if (pending_points.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
          next_point = pending_points.pop_front();
          in_valid <= 1'b1;
          in_point_re <= next_point.re;
          in_point_im <= next_point.im;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: check each result transaction against the oldest prediction
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid === 1'b1 && out_ready) begin
        if (expected_escapes.size() == 0) begin
          report_mismatch("result with no point outstanding");
        end else begin
          oldest_escape = expected_escapes.pop_front();
          if (out_test_count !== oldest_escape.count)
            report_mismatch($sformatf("test_count %0d, expected %0d",
                                      out_test_count, oldest_escape.count));
          if (out_escaped !== oldest_escape.escaped)
            report_mismatch($sformatf("escaped %0b, expected %0b",
                                      out_escaped, oldest_escape.escaped));
        end
      end
      if (hold_requests != holds_served) begin
        holds_served++;
        hold_left = HOLD_OFF_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
      end
    end
  end

  initial begin
    set_idling(24, 87);
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // Reset settings: origin and -2 stay inside, corners escape on their second test
    queue_point(0, 0);
    queue_point(-2 * ONE, 0);
    queue_point(ONE, 0);
    queue_point(WORD_HI, WORD_HI);
    queue_point(WORD_LO, WORD_LO);
    queue_point(WORD_HI, WORD_LO);
    queue_point(WORD_LO, WORD_HI);
    queue_point(0, WORD_LO);
    queue_point(WORD_HI, 0);
    drain();

    // Point 1.0 escapes on its fifth test, the last one at limit 5: the flag stays clear
    write_register(etf_pkg::REG_ITER_LIMIT, 5);
    queue_point(ONE, 0);
    drain();

    // Limit 4 with junk in the upper bits: limit hit
    write_register(etf_pkg::REG_ITER_LIMIT, 32'hABCD_0004);
    queue_point(ONE, 0);
    queue_point(0, 0);
    drain();

    // Zero limit
    write_register(etf_pkg::REG_ITER_LIMIT, 0);
    queue_point(ONE, 0);
    queue_point(0, 0);
    drain();

    // Zero bailout, written with the unused top bit set
    write_register(etf_pkg::REG_ITER_LIMIT, 32'h0000_FFFF);
    write_register(etf_pkg::REG_BAILOUT_SQ, 32'h8000_0000);
    queue_point(0, 0);
    queue_point(-2 * ONE, 0);
    drain();

    // Julia with extreme constants: updates saturate both ways
    configure(1'b1, WORD_HI, WORD_LO, 32'h0000_FFFF, WORD_HI);
    queue_point(0, 0);
    queue_point(10 * ONE, 0);
    queue_point(0, 10 * ONE);
    queue_point(7 * ONE, 7 * ONE);
    queue_point(7 * ONE, -7 * ONE);
    drain();
    configure(1'b1, WORD_LO, WORD_HI, 32'h0000_FFFF, WORD_HI);
    queue_point(7 * ONE, 7 * ONE);
    queue_point(0, 10 * ONE);
    drain();

    // Mandelbrot, small limit; stall the receiver long enough to back up the input
    configure(1'b0, 0, 0, 32, 4 * ONE);
    @(negedge clk);
    hold_requests++;
    queue_points(150, 1'b0);
    drain();

    // Julia near the boundary; writes to unmapped indexes must change nothing
    configure(1'b1, -13421773, 2617246, 64, 4 * ONE);
    for (int idx = etf_pkg::REG_BAILOUT_SQ + 1; idx < (1 << IB); idx++)
      write_register(idx[IB-1:0], '0);
    queue_points(100, 1'b0);
    drain();

    set_idling(87, 24);
    configure(1'b0, 0, 0, 100, 100 * ONE);
    queue_points(100, 1'b0);
    drain();
    for (int rep = 0; rep < 2; rep++) begin
      configure(1'b1, $urandom_range(0, 2 * ONE) - ONE, $urandom_range(0, 2 * ONE) - ONE,
                20, $urandom_range(0, 32'h7FFF_FFFF));
      queue_points(50, 1'b0);
      drain();
    end

    set_idling(0, 0);
    configure(1'b0, 0, 0, 1, $urandom_range(0, 32'h7FFF_FFFF));
    queue_points(40, 1'b0);
    drain();
    configure(1'b0, 0, 0, 2, $urandom_range(0, 32'h7FFF_FFFF));
    queue_points(40, 1'b0);
    drain();
    configure(1'b0, 0, 0, 512, 100 * ONE);
    queue_points(30, 1'b0);
    drain();

    // Largest limit with points that leave quickly, then Julia with extreme constants at limit 16
    configure(1'b0, 0, 0, 32'h0000_FFFF, 100 * ONE);
    queue_points(40, 1'b1);
    drain();
    configure(1'b1, WORD_HI, WORD_LO, 16, WORD_HI);
    queue_points(60, 1'b0);
    drain();
    configure(1'b1, WORD_LO, WORD_HI, 16, WORD_HI);
    queue_points(40, 1'b0);
    drain();

    // Catch any stray result before closing
    repeat (4 * (max_iters + 1) + 8) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  initial begin
    #20_000_000;
    $display("== FAIL ==");
    $finish;
  end

endmodule
